// ===== hw/rtl/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// ANSI SGR color parser package
// Byte codes, SGR codes, the color attribute record and the SGR decoder.
// ----------------------------------------------------------------------------
package asgr_pkg;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_BEL   = 8'h07;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_LBRK  = 8'h5B;
	localparam logic [7:0] BYTE_MINUS = 8'h2D;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;
	localparam logic [7:0] FINAL_LO   = 8'h40;
	localparam logic [7:0] FINAL_HI   = 8'h7E;
	localparam logic [7:0] BYTE_H     = 8'h68;
	localparam logic [7:0] BYTE_L     = 8'h6C;
	localparam logic [7:0] BYTE_M     = 8'h6D;

	localparam logic [7:0] MODE_REPLACE = 8'd21;
	localparam logic [7:0] NUM_MAX      = 8'd255;

	localparam logic [7:0] SGR_RESET      = 8'd0;
	localparam logic [7:0] SGR_BOLD       = 8'd1;
	localparam logic [7:0] SGR_FAINT      = 8'd2;
	localparam logic [7:0] SGR_NORMAL     = 8'd22;
	localparam logic [7:0] SGR_BLINK_SLOW = 8'd5;
	localparam logic [7:0] SGR_BLINK_FAST = 8'd6;
	localparam logic [7:0] SGR_BLINK_OFF  = 8'd25;
	localparam logic [7:0] SGR_FG_FIRST   = 8'd30;
	localparam logic [7:0] SGR_FG_LAST    = 8'd37;
	localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
	localparam logic [7:0] SGR_BG_FIRST   = 8'd40;
	localparam logic [7:0] SGR_BG_LAST    = 8'd47;
	localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;
	localparam logic [7:0] SGR_BG_BRIGHT  = 8'd66;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_BEEP = 1'b1;

	typedef struct packed {
		logic [2:0] fg_idx;
		logic       fg_def;
		logic       fg_intense;
		logic       fg_flash;
		logic [2:0] bg_idx;
		logic       bg_def;
		logic       bg_intense;
	} attr_t;

	localparam attr_t ATTR_RESET = '{
		fg_idx: 3'd0, fg_def: 1'b1, fg_intense: 1'b0, fg_flash: 1'b0,
		bg_idx: 3'd0, bg_def: 1'b1, bg_intense: 1'b0
	};

	function automatic attr_t apply_sgr(input attr_t a, input logic [7:0] v);
		attr_t r;
		r = a;
		case (v) inside
			SGR_RESET: r = ATTR_RESET;
			SGR_BOLD: r.fg_intense = 1'b1;
			SGR_FAINT, SGR_NORMAL: r.fg_intense = 1'b0;
			SGR_BLINK_SLOW, SGR_BLINK_FAST: r.fg_flash = 1'b1;
			SGR_BLINK_OFF: r.fg_flash = 1'b0;
			[SGR_FG_FIRST:SGR_FG_LAST]: begin
				r.fg_idx = v[2:0] - SGR_FG_FIRST[2:0];
				r.fg_def = 1'b0;
			end
			SGR_FG_DEFAULT: begin
				r.fg_idx = 3'd0;
				r.fg_def = 1'b1;
			end
			[SGR_BG_FIRST:SGR_BG_LAST]: begin
				r.bg_idx = v[2:0] - SGR_BG_FIRST[2:0];
				r.bg_def = 1'b0;
			end
			SGR_BG_DEFAULT: begin
				r.bg_idx = 3'd0;
				r.bg_def = 1'b1;
			end
			SGR_BG_BRIGHT: r.bg_intense = 1'b1;
			default: r = a;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/ansi_sgr_color_parser.sv =====
// Output: a result is registered in the cycle after its input transaction.
// Throughput: one byte per cycle while results are taken, except an h, l or m
// final byte of a control sequence with N stored parameters (N <= MAX_PARAMS),
// after which input stalls while the parameter walk reads each entry in S_READ
// and applies it in S_APPLY, through the SGR decoder for an m final byte.
// Reset: asynchronous, active low; colors to default, replace mode on, idle.
// ----------------------------------------------------------------------------
// ANSI SGR color parser
// Passes text bytes with color attributes and interprets SGR and h/l sequences.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser import asgr_pkg::*; #(
	parameter int MAX_PARAMS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [6:0] char_code,
	output logic [2:0] fg_color,
	output logic       fg_is_default,
	output logic       fg_intense,
	output logic       fg_blinking,
	output logic [2:0] bg_color,
	output logic       bg_is_default,
	output logic       bg_intense
);

	localparam int CNT_W = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_APPLY} state_t;
	typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_CSI} phase_t;
	typedef enum logic [1:0] {OP_NONE, OP_SET, OP_CLR, OP_SGR} op_t;

	state_t           state_q;
	phase_t           phase_q;
	op_t              op_q;
	logic             beep_en_q;
	logic             replace_q;
	attr_t            attr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] walk_q;
	logic [7:0]       acc_q;
	logic             active_q;
	logic             sign_q;
	logic [7:0]       val_mem [MAX_PARAMS];
	logic             neg_mem [MAX_PARAMS];
	logic [7:0]       val_rd_q;
	logic             neg_rd_q;

	logic             accept;
	logic             csi_mode;
	logic             is_digit;
	logic             is_final;
	logic             cnt_full;
	logic [11:0]      acc_mul;
	logic [7:0]       acc_sat;
	logic             wr_val;
	logic             wr_neg;
	logic [CNT_W-1:0] cnt_end;
	op_t              op_new;
	logic [CNT_W-1:0] walk_nxt;
	logic             plain_byte;
	logic             out_load;

	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign accept   = in_valid && in_ready;
	assign csi_mode = (phase_q == PH_CSI);
	assign is_digit = (byte_value >= BYTE_ZERO) && (byte_value <= BYTE_NINE);
	assign is_final = (byte_value >= FINAL_LO) && (byte_value <= FINAL_HI);
	assign cnt_full = (cnt_q == CNT_W'(MAX_PARAMS));
	assign acc_mul  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {8'd0, byte_value[3:0]};
	assign acc_sat  = (acc_mul > {4'd0, NUM_MAX}) ? NUM_MAX : acc_mul[7:0];
	assign wr_val   = accept && csi_mode && !(is_digit && !is_final) && active_q && !cnt_full;
	assign wr_neg   = accept && csi_mode && is_digit && !active_q && !cnt_full;
	assign cnt_end  = wr_val ? cnt_q + CNT_W'(1) : cnt_q;
	assign walk_nxt = walk_q + CNT_W'(1);

	assign plain_byte = !csi_mode && !(phase_q == PH_ESC && byte_value == BYTE_LBRK);
	assign out_load   = accept && plain_byte && !byte_value[7] &&
		((byte_value == BYTE_BEL) ? beep_en_q :
		(byte_value != BYTE_ESC && byte_value != BYTE_CR && byte_value != BYTE_NUL));

	always_comb begin
		case (byte_value)
			BYTE_H:  op_new = OP_SET;
			BYTE_L:  op_new = OP_CLR;
			BYTE_M:  op_new = OP_SGR;
			default: op_new = OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_val) begin
			val_mem[cnt_q[IDX_W-1:0]] <= acc_q;
		end
		if (wr_neg) begin
			neg_mem[cnt_q[IDX_W-1:0]] <= sign_q;
		end
		if (state_q == S_READ) begin
			val_rd_q <= val_mem[walk_q[IDX_W-1:0]];
			neg_rd_q <= neg_mem[walk_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_IDLE;
			op_q          <= OP_NONE;
			beep_en_q     <= 1'b0;
			replace_q     <= 1'b1;
			attr_q        <= ATTR_RESET;
			cnt_q         <= '0;
			walk_q        <= '0;
			acc_q         <= '0;
			active_q      <= 1'b0;
			sign_q        <= 1'b0;
			out_valid     <= 1'b0;
			kind          <= KIND_TEXT;
			char_code     <= '0;
			fg_color      <= '0;
			fg_is_default <= 1'b0;
			fg_intense    <= 1'b0;
			fg_blinking   <= 1'b0;
			bg_color      <= '0;
			bg_is_default <= 1'b0;
			bg_intense    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				beep_en_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (phase_q == PH_ESC && byte_value == BYTE_LBRK) begin
							phase_q  <= PH_CSI;
							cnt_q    <= '0;
							acc_q    <= '0;
							active_q <= 1'b0;
							sign_q   <= 1'b0;
						end else if (csi_mode && is_final) begin
							acc_q    <= '0;
							active_q <= 1'b0;
							sign_q   <= 1'b0;
							op_q     <= op_new;
							walk_q   <= '0;
							if (op_new == OP_SGR && !replace_q) begin
								attr_q <= ATTR_RESET;
							end
							if (op_new != OP_NONE && cnt_end != '0) begin
								state_q <= S_READ;
								cnt_q   <= cnt_end;
							end else begin
								phase_q <= PH_IDLE;
								cnt_q   <= '0;
							end
						end else if (csi_mode) begin
							if (is_digit) begin
								active_q <= 1'b1;
								sign_q   <= 1'b0;
								acc_q    <= active_q ? acc_sat : 8'(byte_value[3:0]);
							end else begin
								cnt_q    <= cnt_end;
								active_q <= 1'b0;
								acc_q    <= '0;
								sign_q   <= (byte_value == BYTE_MINUS);
							end
						end else begin
							phase_q <= (byte_value == BYTE_ESC) ? PH_ESC : PH_IDLE;
							if (byte_value == BYTE_BEL) begin
								if (beep_en_q) begin
									kind          <= KIND_BEEP;
									char_code     <= '0;
									fg_color      <= '0;
									fg_is_default <= 1'b0;
									fg_intense    <= 1'b0;
									fg_blinking   <= 1'b0;
									bg_color      <= '0;
									bg_is_default <= 1'b0;
									bg_intense    <= 1'b0;
								end
							end else if (byte_value != BYTE_ESC && byte_value != BYTE_CR &&
								byte_value != BYTE_NUL && !byte_value[7]) begin
								kind          <= KIND_TEXT;
								char_code     <= byte_value[6:0];
								fg_color      <= attr_q.fg_def ? 3'd0 : attr_q.fg_idx;
								fg_is_default <= attr_q.fg_def;
								fg_intense    <= attr_q.fg_intense;
								fg_blinking   <= attr_q.fg_def ? 1'b0 : attr_q.fg_flash;
								bg_color      <= attr_q.bg_def ? 3'd0 : attr_q.bg_idx;
								bg_is_default <= attr_q.bg_def;
								bg_intense    <= attr_q.bg_def ? 1'b0 : attr_q.bg_intense;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (!neg_rd_q) begin
						case (op_q)
							OP_SET: if (val_rd_q == MODE_REPLACE) replace_q <= 1'b1;
							OP_CLR: if (val_rd_q == MODE_REPLACE) replace_q <= 1'b0;
							OP_SGR: attr_q <= apply_sgr(attr_q, val_rd_q);
							default: attr_q <= attr_q;
						endcase
					end
					walk_q <= walk_nxt;
					if (walk_nxt == cnt_q) begin
						state_q <= S_IDLE;
						phase_q <= PH_IDLE;
						cnt_q   <= '0;
					end else begin
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
